>>> sv/wavhp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wavhp_pkg
// shared types, codes and constants of the riff/wave header parser
// ----------------------------------------------------------------------------
package wavhp_pkg;

	localparam int unsigned REC_LEN = 18;

	// parser phases
	localparam logic [3:0] PH_RIFF  = 4'd0;
	localparam logic [3:0] PH_RSIZE = 4'd1;
	localparam logic [3:0] PH_WAVE  = 4'd2;
	localparam logic [3:0] PH_HDR   = 4'd3;
	localparam logic [3:0] PH_FMT   = 4'd4;
	localparam logic [3:0] PH_SKIP  = 4'd5;

	// result status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NO_RIFF = 3'd1;
	localparam logic [2:0] ST_NO_WAVE = 3'd2;
	localparam logic [2:0] ST_NO_PCM  = 3'd3;
	localparam logic [2:0] ST_TRUNC   = 3'd4;

	// chunk ids as they arrive, first byte in the top bits
	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [15:0] FMT_PCM = 16'd1;

	// pcm, 2 ch, 48000 Hz, 192000 B/s, align 4, 16 bit, extra 0
	localparam logic [REC_LEN-1:0][7:0] REC_DEFAULT = {
		8'h00, 8'h00, 8'h00, 8'h10, 8'h00, 8'h04,
		8'h00, 8'h02, 8'hEE, 8'h00, 8'h00, 8'h00,
		8'hBB, 8'h80, 8'h00, 8'h02, 8'h00, 8'h01
	};

	typedef logic [REC_LEN-1:0][7:0] rec_t;

	typedef struct packed {
		logic [3:0]  phase;
		logic [31:0] cnt;
		logic [31:0] tag;
		logic [31:0] len;
		rec_t        rec;
		logic        fin;
	} parse_state_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] data_size;
		logic [15:0] extra_size;
		logic [15:0] bits_per_sample;
		logic [15:0] block_align;
		logic [31:0] byte_rate;
		logic [31:0] sample_rate;
		logic [15:0] channels;
		logic [15:0] format_tag;
		logic [2:0]  status;
	} res_t;

	function automatic parse_state_t rearm_state();
		parse_state_t s;
		s.phase = PH_RIFF;
		s.cnt   = '0;
		s.tag   = '0;
		s.len   = '0;
		s.rec   = REC_DEFAULT;
		s.fin   = 1'b0;
		return s;
	endfunction

endpackage
`default_nettype wire

>>> sv/wavhp_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wavhp_in_reg
// input register: holds one byte beat until the parser steps on it
// ----------------------------------------------------------------------------
module wavhp_in_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire wavhp_pkg::in_beat_t in_beat,
	input  wire logic              step_en,
	output logic                   valid_s1,
	output wavhp_pkg::in_beat_t    beat_s1
);

	logic vld_s1;

	// free when empty or when the held beat is consumed this cycle
	assign in_ready = !vld_s1 || step_en;
	assign valid_s1 = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_s1 <= in_beat;
		end
	end

endmodule
`default_nettype wire

>>> sv/wavhp_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wavhp_step
// next-state and result logic for one file byte
// ----------------------------------------------------------------------------
module wavhp_step (
	input  wire wavhp_pkg::parse_state_t st,
	input  wire wavhp_pkg::in_beat_t     beat,
	output wavhp_pkg::parse_state_t      nxt,
	output logic                         res_valid,
	output wavhp_pkg::res_t              res
);

	always_comb begin
		logic [31:0] cnt_inc;
		logic [31:0] fill;
		logic [31:0] len_base;
		logic [2:0]  status;
		logic        emit;
		logic [7:0]  b;

		b        = beat.in_byte;
		nxt      = st;
		emit     = 1'b0;
		status   = wavhp_pkg::ST_OK;
		cnt_inc  = st.cnt + 32'd1;
		fill     = (st.len < 32'(wavhp_pkg::REC_LEN)) ? st.len : 32'(wavhp_pkg::REC_LEN);
		len_base = (st.cnt == 32'd0) ? 32'd0 : st.len;

		if (!st.fin) begin
			unique case (st.phase) inside
				wavhp_pkg::PH_RIFF, wavhp_pkg::PH_RSIZE, wavhp_pkg::PH_WAVE: begin
					nxt.tag = {st.tag[23:0], b};
					nxt.cnt = cnt_inc;
					if (cnt_inc == 32'd4) begin
						nxt.cnt = '0;
						if (st.phase == wavhp_pkg::PH_RIFF) begin
							if (nxt.tag != wavhp_pkg::TAG_RIFF) begin
								emit   = 1'b1;
								status = wavhp_pkg::ST_NO_RIFF;
							end else begin
								nxt.phase = wavhp_pkg::PH_RSIZE;
							end
						end else if (st.phase == wavhp_pkg::PH_RSIZE) begin
							nxt.phase = wavhp_pkg::PH_WAVE;
						end else if (nxt.tag != wavhp_pkg::TAG_WAVE) begin
							emit   = 1'b1;
							status = wavhp_pkg::ST_NO_WAVE;
						end else begin
							nxt.phase = wavhp_pkg::PH_HDR;
						end
					end
				end
				wavhp_pkg::PH_HDR: begin
					nxt.len = len_base;
					if (st.cnt < 32'd4) begin
						nxt.tag = {st.tag[23:0], b};
					end else begin
						// size field, little-endian
						case (st.cnt[1:0])
							2'd0:    nxt.len[7:0]   = len_base[7:0]   | b;
							2'd1:    nxt.len[15:8]  = len_base[15:8]  | b;
							2'd2:    nxt.len[23:16] = len_base[23:16] | b;
							default: nxt.len[31:24] = len_base[31:24] | b;
						endcase
					end
					nxt.cnt = cnt_inc;
					if (cnt_inc >= 32'd8) begin
						nxt.cnt = '0;
						if (nxt.tag == wavhp_pkg::TAG_FMT) begin
							if (nxt.len == 32'd0) begin
								if ({st.rec[1], st.rec[0]} != wavhp_pkg::FMT_PCM) begin
									emit   = 1'b1;
									status = wavhp_pkg::ST_NO_PCM;
								end
							end else begin
								nxt.phase = wavhp_pkg::PH_FMT;
							end
						end else if (nxt.tag == wavhp_pkg::TAG_DATA) begin
							emit   = 1'b1;
							status = wavhp_pkg::ST_OK;
						end else if (nxt.len != 32'd0) begin
							nxt.phase = wavhp_pkg::PH_SKIP;
						end
					end
				end
				wavhp_pkg::PH_FMT: begin
					for (int i = 0; i < int'(wavhp_pkg::REC_LEN); i++) begin
						if (st.cnt == 32'(i)) begin
							nxt.rec[i] = b;
						end
					end
					nxt.cnt = cnt_inc;
					if (cnt_inc == fill &&
					    {nxt.rec[1], nxt.rec[0]} != wavhp_pkg::FMT_PCM) begin
						emit   = 1'b1;
						status = wavhp_pkg::ST_NO_PCM;
					end else if (cnt_inc == st.len) begin
						nxt.phase = wavhp_pkg::PH_HDR;
						nxt.cnt   = '0;
					end
				end
				default: begin
					nxt.cnt = cnt_inc;
					if (cnt_inc == st.len) begin
						nxt.phase = wavhp_pkg::PH_HDR;
						nxt.cnt   = '0;
					end
				end
			endcase

			if (emit) begin
				nxt.fin = 1'b1;
			end
			if (beat.last_byte && !emit) begin
				emit   = 1'b1;
				status = wavhp_pkg::ST_TRUNC;
			end
		end

		// result fields come from the record as it stands after this byte
		res.status          = status;
		res.format_tag      = {nxt.rec[1], nxt.rec[0]};
		res.channels        = {nxt.rec[3], nxt.rec[2]};
		res.sample_rate     = {nxt.rec[7], nxt.rec[6], nxt.rec[5], nxt.rec[4]};
		res.byte_rate       = {nxt.rec[11], nxt.rec[10], nxt.rec[9], nxt.rec[8]};
		res.block_align     = {nxt.rec[13], nxt.rec[12]};
		res.bits_per_sample = {nxt.rec[15], nxt.rec[14]};
		res.extra_size      = {nxt.rec[17], nxt.rec[16]};
		res.data_size       = (status == wavhp_pkg::ST_OK) ? nxt.len : 32'd0;
		res_valid           = emit;

		if (beat.last_byte) begin
			nxt = wavhp_pkg::rearm_state();
		end
	end

endmodule
`default_nettype wire

>>> sv/wavhp_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wavhp_out_reg
// result register on the output stream
// ----------------------------------------------------------------------------
module wavhp_out_reg (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           load,
	input  wire wavhp_pkg::res_t res_in,
	output logic                out_valid,
	input  wire logic           out_ready,
	output wavhp_pkg::res_t     res_q,
	output logic                free
);

	logic vld_q;

	assign out_valid = vld_q;
	assign free      = !vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (out_ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule
`default_nettype wire

>>> sv/wav_header_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wav_header_parser_core
// riff/wave header parser, one file byte per beat
// ----------------------------------------------------------------------------
// Feed a WAVE file one byte per input beat, with tlast on its final byte. The
// block checks the RIFF and WAVE tags, walks the sub-chunks, loads the first
// up to 18 bytes of each fmt chunk into the format record and skips all other
// chunk bodies; a data header ends the parse. Each file yields exactly one
// output beat: status ok with the data size, or an error code (not riff, not
// wave, not pcm, truncated) with the format record as it stood. Bytes after
// the result are dropped until tlast, which rearms the parser. One byte is
// taken per cycle; a byte passes through an input register and one step of
// the parser state update, and its result is held in the result register.
// Input only stalls while the result register is full and not being taken.
// ----------------------------------------------------------------------------
module wav_header_parser_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [7:0]   s_axis_tdata,  // in_byte
	input  wire logic         s_axis_tlast,  // last_byte
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// status[2:0], format_tag[18:3], channels[34:19], sample_rate[66:35],
	// byte_rate[98:67], block_align[114:99], bits_per_sample[130:115],
	// extra_size[146:131], data_size[178:147], zero fill [183:179]
	output logic [183:0]      m_axis_tdata
);

	wavhp_pkg::in_beat_t     in_beat;
	wavhp_pkg::in_beat_t     beat_s1;
	wavhp_pkg::parse_state_t st_q;
	wavhp_pkg::parse_state_t st_nxt;
	wavhp_pkg::res_t         res;
	wavhp_pkg::res_t         res_q;
	logic                    valid_s1;
	logic                    step_en;
	logic                    res_valid;
	logic                    out_free;

	assign in_beat.in_byte   = s_axis_tdata;
	assign in_beat.last_byte = s_axis_tlast;
	assign step_en           = valid_s1 && out_free;

	wavhp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_beat  (in_beat),
		.step_en  (step_en),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	wavhp_step u_step (
		.st        (st_q),
		.beat      (beat_s1),
		.nxt       (st_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= wavhp_pkg::rearm_state();
		end else if (step_en) begin
			st_q <= st_nxt;
		end
	end

	wavhp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step_en && res_valid),
		.res_in    (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.res_q     (res_q),
		.free      (out_free)
	);

	assign m_axis_tdata = {5'b0, res_q};

`ifndef ASSERT_OFF
	// a finished parse stays silent until the file ends
	a_quiet_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && st_q.fin |-> !res_valid)
		else $error("result produced after parse finished");

	// the last byte of a file always rearms the parser
	a_rearm_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && beat_s1.last_byte |=>
		st_q.phase == wavhp_pkg::PH_RIFF && !st_q.fin && st_q.cnt == 32'd0)
		else $error("parser not rearmed after last byte");

	// a result before the last byte marks the file as finished
	a_fin_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res_valid && !beat_s1.last_byte |=> st_q.fin)
		else $error("result did not mark the parse finished");

	// error results never carry a data size
	a_err_no_size: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != wavhp_pkg::ST_OK |-> res.data_size == 32'd0)
		else $error("error result with nonzero data size");
`endif

endmodule
`default_nettype wire
